FILE: rtl/assert_macros.svh
// Assertion helpers used by the css_queue module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every clock outside reset.
`define CSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication every clock outside reset.
`define CSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg: content type sniffer package
// Signature tables, type codes and the result item type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package css_pkg;

  localparam int NExact = 13;
  localparam int NTag   = 18;

  localparam logic [4:0] TypeOctet = 5'd0;
  localparam logic [4:0] TypeText  = 5'd1;
  localparam logic [4:0] TypeWebp  = 5'd14;
  localparam logic [4:0] TypeWave  = 5'd15;
  localparam logic [4:0] TypeXml   = 5'd16;
  localparam logic [4:0] TypeHtml  = 5'd17;
  localparam logic [4:0] TypeMp4   = 5'd18;

  localparam logic [4:0] TagSat = 5'd31;

  localparam logic [7:0] EXACT_SIG [NExact][11] = '{
    '{8'h47,8'h49,8'h46,8'h38,8'h37,8'h61,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h47,8'h49,8'h46,8'h38,8'h39,8'h61,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h89,8'h50,8'h4e,8'h47,8'h0d,8'h0a,8'h1a,8'h0a,8'h00,8'h00,8'h00},
    '{8'hff,8'hd8,8'hff,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h42,8'h4d,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h4f,8'h67,8'h67,8'h53,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h1a,8'h45,8'hdf,8'ha3,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h52,8'h61,8'h72,8'h20,8'h1a,8'h07,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h50,8'h4b,8'h03,8'h04,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h1f,8'h8b,8'h08,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h25,8'h21,8'h50,8'h53,8'h2d,8'h41,8'h64,8'h6f,8'h62,8'h65,8'h2d},
    '{8'h25,8'h50,8'h44,8'h46,8'h2d,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };
  localparam logic [3:0] EXACT_LEN [NExact] =
    '{4'd6,4'd6,4'd8,4'd3,4'd2,4'd4,4'd5,4'd4,4'd7,4'd4,4'd3,4'd11,4'd5};
  localparam logic [4:0] EXACT_CODE [NExact] =
    '{5'd2,5'd2,5'd3,5'd4,5'd5,5'd6,5'd7,5'd8,5'd9,5'd10,5'd11,5'd12,5'd13};

  localparam logic [7:0] BOM_SIG [3][3] = '{
    '{8'hfe,8'hff,8'h00}, '{8'hff,8'hfe,8'h00}, '{8'hef,8'hbb,8'hbf}
  };
  localparam logic [1:0] BOM_LEN [3] = '{2'd2,2'd2,2'd3};

  localparam logic [7:0] RIFF_SIG [4] = '{8'h52,8'h49,8'h46,8'h46};
  localparam logic [7:0] WEBP_SIG [8] =
    '{8'h57,8'h45,8'h42,8'h50,8'h56,8'h50,8'h00,8'h00};
  localparam logic [7:0] WAVE_SIG [4] = '{8'h57,8'h41,8'h56,8'h45};
  localparam logic [7:0] FTYP_SIG [4] = '{8'h66,8'h74,8'h79,8'h70};

  // Tag zero is exact XML, the rest compare against upper-case folded bytes
  localparam logic [7:0] TAG_SIG [NTag][16] = '{
    '{"<","?","x","m","l",0,0,0,0,0,0,0,0,0,0,0},
    '{"<","!","D","O","C","T","Y","P","E"," ","H","T","M","L",0,0},
    '{"<","H","T","M","L",0,0,0,0,0,0,0,0,0,0,0},
    '{"<","H","E","A","D",0,0,0,0,0,0,0,0,0,0,0},
    '{"<","S","C","R","I","P","T",0,0,0,0,0,0,0,0,0},
    '{"<","I","F","R","A","M","E",0,0,0,0,0,0,0,0,0},
    '{"<","H","1",0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{"<","D","I","V",0,0,0,0,0,0,0,0,0,0,0,0},
    '{"<","F","O","N","T",0,0,0,0,0,0,0,0,0,0,0},
    '{"<","T","A","B","L","E",0,0,0,0,0,0,0,0,0,0},
    '{"<","A",0,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{"<","S","T","Y","L","E",0,0,0,0,0,0,0,0,0,0},
    '{"<","T","I","T","L","E",0,0,0,0,0,0,0,0,0,0},
    '{"<","B",0,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{"<","B","O","D","Y",0,0,0,0,0,0,0,0,0,0,0},
    '{"<","B","R",0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{"<","P",0,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{"<","!","-","-",0,0,0,0,0,0,0,0,0,0,0,0}
  };
  localparam logic [4:0] TAG_LEN [NTag] = '{5'd5,5'd14,5'd5,5'd5,5'd7,5'd7,5'd3,5'd4,
    5'd5,5'd6,5'd2,5'd6,5'd6,5'd2,5'd5,5'd3,5'd2,5'd4};

  typedef struct packed {
    logic [4:0] type_code;
    logic [9:0] bytes_examined;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/css_ifc.sv
// ----------------------------------------------------------------------------
// Sniffer channels
// Valid/ready channels for body bytes and for result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface css_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface css_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] type_code;
  logic [9:0] bytes_examined;
  modport source (output valid, output type_code, output bytes_examined, input ready);
  modport sink (input valid, input type_code, input bytes_examined, output ready);
endinterface
`default_nettype wire

FILE: rtl/css_front.sv
// ----------------------------------------------------------------------------
// css_front: byte classifier
// Updates signature match flags per byte and decides the type at the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module css_front #(
  parameter int WINDOW = 512
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  input  wire logic            acc,
  input  wire logic [7:0]      b,
  input  wire logic            last,
  output css_pkg::result_t     res,
  output logic                 push
);
  localparam int PW = $clog2(WINDOW + 1);

  logic          mode_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          bin_r, bin_nxt;
  logic [12:0]   ex_r, ex_nxt;
  logic [2:0]    riff_r, riff_nxt, bom_r, bom_nxt;
  logic          lead_r, lead_nxt;
  logic [4:0]    toff_r, toff_nxt;
  logic [17:0]   tc_r, tc_nxt, th_r, th_nxt;
  logic [31:0]   box_r, box_nxt;
  logic [2:0]    bf_r, bf_nxt;
  logic          take;
  logic [7:0]    fb, tv;
  logic [2:0]    p8;
  logic [4:0]    code, sig;
  logic          bom_hit;
  logic [PW-1:0] len;

  assign take = acc && (pos_r < PW'(WINDOW));
  assign p8   = 3'(pos_r - PW'(8));
  assign fb   = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;

  // Next match state for this byte
  always_comb begin
    ex_nxt = ex_r; bom_nxt = bom_r; riff_nxt = riff_r; lead_nxt = lead_r;
    toff_nxt = toff_r; tc_nxt = tc_r; th_nxt = th_r; box_nxt = box_r;
    bf_nxt = bf_r; bin_nxt = bin_r; tv = 8'd0;
    for (int i = 0; i < css_pkg::NExact; i++) begin
      if (pos_r < PW'(css_pkg::EXACT_LEN[i]) && b != css_pkg::EXACT_SIG[i][pos_r[3:0]])
        ex_nxt[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (pos_r < PW'(css_pkg::BOM_LEN[i]) && b != css_pkg::BOM_SIG[i][pos_r[1:0]])
        bom_nxt[i] = 1'b0;
    end
    if (pos_r < PW'(4) && b != css_pkg::RIFF_SIG[pos_r[1:0]]) riff_nxt[0] = 1'b0;
    if (pos_r >= PW'(8) && pos_r < PW'(14) && b != css_pkg::WEBP_SIG[p8]) riff_nxt[1] = 1'b0;
    if (pos_r >= PW'(8) && pos_r < PW'(12) && b != css_pkg::WAVE_SIG[p8[1:0]])
      riff_nxt[2] = 1'b0;
    // Skip leading whitespace, then match tags
    if (!(lead_r && (b == 8'h09 || b == 8'h0a || b == 8'h0c || b == 8'h0d || b == 8'h20)))
    begin
      lead_nxt = 1'b0;
      for (int t = 0; t < css_pkg::NTag; t++) begin
        if (toff_r < css_pkg::TAG_LEN[t]) begin
          tv = (t == 0) ? b : fb;
          if (tv != css_pkg::TAG_SIG[t][toff_r[3:0]])
            tc_nxt[t] = 1'b0;
          else if (t == 0 && toff_r + 5'd1 == css_pkg::TAG_LEN[t] && tc_r[t])
            th_nxt[t] = 1'b1;
        end else if (toff_r == css_pkg::TAG_LEN[t] && t != 0) begin
          if (tc_r[t] && (b == 8'h20 || b == 8'h3e)) th_nxt[t] = 1'b1;
        end
      end
      if (toff_r < css_pkg::TagSat) toff_nxt = toff_r + 5'd1;
    end
    // Track the MP4 box header and brands
    if (pos_r < PW'(4)) begin
      box_nxt = {box_r[23:0], b};
    end else if (pos_r < PW'(8)) begin
      if (b != css_pkg::FTYP_SIG[pos_r[1:0]]) bf_nxt[0] = 1'b1;
    end else begin
      case (pos_r[1:0])
        2'd0: bf_nxt[1] = (pos_r == PW'(8) || (pos_r >= PW'(16) &&
                           33'(pos_r) + 33'd4 <= {1'b0, box_r})) && b == 8'h6d;
        2'd1: if (b != 8'h70) bf_nxt[1] = 1'b0;
        2'd2: begin
          if (bf_r[1] && b == 8'h34) bf_nxt[2] = 1'b1;
          bf_nxt[1] = 1'b0;
        end
        default: ;
      endcase
    end
    if (b <= 8'h1f && b != 8'h1b && b != 8'h0d && b != 8'h0c && b != 8'h0a && b != 8'h09)
      bin_nxt = 1'b1;
    if (!take) begin
      ex_nxt = ex_r; bom_nxt = bom_r; riff_nxt = riff_r; lead_nxt = lead_r;
      toff_nxt = toff_r; tc_nxt = tc_r; th_nxt = th_r; box_nxt = box_r;
      bf_nxt = bf_r; bin_nxt = bin_r;
    end
    pos_nxt = take ? pos_r + PW'(1) : pos_r;
  end

  // Decide the type from the state after this byte
  always_comb begin
    len = pos_nxt;
    sig = css_pkg::TypeOctet;
    bom_hit = 1'b0;
    for (int i = 0; i < 3; i++)
      if (bom_nxt[i] && len >= PW'(css_pkg::BOM_LEN[i])) bom_hit = 1'b1;
    if (len >= PW'(12) && riff_nxt[0] && riff_nxt[2]) sig = css_pkg::TypeWave;
    if (len >= PW'(14) && riff_nxt[0] && riff_nxt[1]) sig = css_pkg::TypeWebp;
    for (int i = css_pkg::NExact - 1; i >= 0; i--)
      if (ex_nxt[i] && len >= PW'(css_pkg::EXACT_LEN[i]) &&
          (!mode_r || i != css_pkg::NExact - 1))
        sig = css_pkg::EXACT_CODE[i];
    if (mode_r) begin
      code = (bom_hit || !bin_nxt) ? css_pkg::TypeText : sig;
    end else if (sig != css_pkg::TypeOctet) begin
      code = sig;
    end else if (bom_hit) begin
      code = css_pkg::TypeText;
    end else if (th_nxt[0]) begin
      code = css_pkg::TypeXml;
    end else if (|th_nxt[17:1]) begin
      code = css_pkg::TypeHtml;
    end else if (len >= PW'(12) && box_nxt != 32'd0 && box_nxt[1:0] == 2'd0 &&
                 box_nxt <= 32'(len) && !bf_nxt[0] && bf_nxt[2]) begin
      code = css_pkg::TypeMp4;
    end else begin
      code = bin_nxt ? css_pkg::TypeOctet : css_pkg::TypeText;
    end
  end

  assign push = acc && last;
  assign res  = '{type_code: code, bytes_examined: 10'(len)};

  // Hold mode; advance or clear the per-body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
    if (!rst_n || push) begin
      pos_r <= '0; bin_r <= 1'b0; ex_r <= '1; riff_r <= '1; bom_r <= '1;
      lead_r <= 1'b1; toff_r <= '0; tc_r <= '1; th_r <= '0; box_r <= '0; bf_r <= '0;
    end else begin
      pos_r <= pos_nxt; bin_r <= bin_nxt; ex_r <= ex_nxt; riff_r <= riff_nxt;
      bom_r <= bom_nxt; lead_r <= lead_nxt; toff_r <= toff_nxt; tc_r <= tc_nxt;
      th_r <= th_nxt; box_r <= box_nxt; bf_r <= bf_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/css_queue.sv
// ----------------------------------------------------------------------------
// css_queue: result queue
// Two-entry queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module css_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  css_pkg::result_t       wdata,
  input  wire logic              pop,
  output css_pkg::result_t       rdata,
  output logic                   full,
  output logic                   empty
);
  css_pkg::result_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  // Store the item at the write pointer
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `CSS_ASSERT(a_no_overflow, !(push && full && !pop), "push into full queue")
  `CSS_ASSERT(a_no_underflow, !(pop && empty), "pop from empty queue")
  `CSS_ASSERT(a_cnt_range, cnt_r != 2'd3, "queue count out of range")
  `CSS_ASSERT_IMP(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "count did not rise")
endmodule
`default_nettype wire

FILE: rtl/css_back.sv
// ----------------------------------------------------------------------------
// css_back: output stage
// Registers result items toward the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module css_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          empty,
  input  css_pkg::result_t   rdata,
  output logic               pop,
  css_out_if.source          out_ch
);
  logic             vld_r;
  css_pkg::result_t dat_r;

  assign pop = !empty && (!vld_r || out_ch.ready);
  assign out_ch.valid          = vld_r;
  assign out_ch.type_code      = dat_r.type_code;
  assign out_ch.bytes_examined = dat_r.bytes_examined;

  // Load the next item when the register frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
    if (pop) dat_r <= rdata;
  end
endmodule
`default_nettype wire

FILE: rtl/content_type_sniffer_unit.sv
// Result path: the last byte of a body writes its result into the result queue,
// and the result then moves into the output register that drives out_ch.valid.
// Throughput: one body byte per cycle; a stalled output only blocks input
// once the two-entry result queue and the output register are full.
// Reset: synchronous active-low rst_n clears the body state, the queue,
// and the mode register (unknown-type sniffing).
// ----------------------------------------------------------------------------
// content_type_sniffer_unit: streaming content type sniffer
// Classifies a byte stream and emits one type code per body.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module content_type_sniffer_unit #(
  parameter int WINDOW = 512
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  css_in_if.sink    in_ch,
  css_out_if.source out_ch
);
  css_pkg::result_t res, rdata;
  logic push, pop, full, empty, acc;

  // Accept bytes whenever the queue has room
  assign in_ch.ready = !full;
  assign acc = in_ch.valid && !full;

  css_front #(.WINDOW(WINDOW)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .acc(acc), .b(in_ch.data_byte), .last(in_ch.last), .res(res), .push(push)
  );

  css_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(res), .pop(pop),
    .rdata(rdata), .full(full), .empty(empty)
  );

  css_back u_back (
    .clk(clk), .rst_n(rst_n), .empty(empty), .rdata(rdata), .pop(pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire
